@@ rtl/tbms_pkg.sv @@
// Package with types and constants shared by the score tracker modules.
package tbms_pkg;

  localparam int unsigned ScoreW = 48;
  localparam int unsigned PivW = 10;
  localparam int unsigned NumPiv = 8;
  localparam int unsigned TupleW = PivW * NumPiv;
  localparam int unsigned EntryW = ScoreW + TupleW;

  localparam logic [1:0] OpOffer = 2'd0;
  localparam logic [1:0] OpReadLarge = 2'd1;
  localparam logic [1:0] OpReadSmall = 2'd2;
  localparam logic [1:0] OpNone = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] slot;
    logic [ScoreW-1:0] score;
    logic [PivW-1:0] pivot_0;
    logic [PivW-1:0] pivot_1;
    logic [PivW-1:0] pivot_2;
    logic [PivW-1:0] pivot_3;
    logic [PivW-1:0] pivot_4;
    logic [PivW-1:0] pivot_5;
    logic [PivW-1:0] pivot_6;
    logic [PivW-1:0] pivot_7;
  } in_word_t;

  typedef struct packed {
    logic [ScoreW-1:0] out_score;
    logic [PivW-1:0] out_pivot_0;
    logic [PivW-1:0] out_pivot_1;
    logic [PivW-1:0] out_pivot_2;
    logic [PivW-1:0] out_pivot_3;
    logic [PivW-1:0] out_pivot_4;
    logic [PivW-1:0] out_pivot_5;
    logic [PivW-1:0] out_pivot_6;
    logic [PivW-1:0] out_pivot_7;
    logic slot_valid;
    logic took_largest;
    logic took_smallest;
  } out_word_t;

  // Memory access from the controller to one heap store.
  typedef struct packed {
    logic we;
    logic [15:0] waddr;
    logic [EntryW-1:0] wdata;
    logic [15:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/top_bottom_m_score_tracker.sv @@
// Top level of the top/bottom-M score tracker with its sequencer.
// The block keeps the HEAP_SIZE largest scores in a min-heap and the HEAP_SIZE
// smallest in a max-heap, each in its own memory with a registered read. It
// handles one word at a time and keeps its input stalled until the result word
// has been taken. A read passes StReadW and StReadD before StOut, the unused op
// goes straight to StOut, and an offer while filling writes both stores in StRoot
// before StOut. The offer that fills the last slot builds both heaps, one after
// the other. A later offer looks at both roots and sifts each heap that takes it;
// each sift level reads the left child, reads the right child, then compares and
// writes.
module top_bottom_m_score_tracker #(
  parameter int unsigned HEAP_SIZE = 1024,
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned MAX_PIVOTS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  tbms_pkg::in_word_t in_data_i,
  output logic out_valid,
  input  logic out_stall,
  output tbms_pkg::out_word_t out_data_o,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [3:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(HEAP_SIZE);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = tbms_pkg::ScoreW;
  localparam int unsigned EW = tbms_pkg::EntryW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StReadW = 4'd1;
  localparam logic [3:0] StReadD = 4'd2;
  localparam logic [3:0] StRdP = 4'd3;
  localparam logic [3:0] StRdL = 4'd4;
  localparam logic [3:0] StRdR = 4'd5;
  localparam logic [3:0] StCmp = 4'd6;
  localparam logic [3:0] StNext = 4'd7;
  localparam logic [3:0] StOut = 4'd8;
  localparam logic [3:0] StRoot = 4'd9;
  localparam logic [3:0] StRootD = 4'd10;

  logic [3:0] state_q, state_d;
  logic [3:0] piv_q;
  logic [CW-1:0] fill_q, fill_d;
  tbms_pkg::in_word_t cur_q, cur_d;
  tbms_pkg::out_word_t res_q, res_d;
  logic [EW-1:0] new_q, new_d;
  logic [EW-1:0] pe_q, pe_d, le_q, le_d;
  logic [CW-1:0] par_q, par_d, ch_q, ch_d;
  logic [CW-1:0] bld_q, bld_d;
  logic heap_q, heap_d;   // 0: largest set (min-heap), 1: smallest set
  logic build_q, build_d;
  logic pend_q, pend_d;   // smallest set still to be processed after largest
  logic outv_q;

  tbms_pkg::mem_req_t req_l, req_s, req;
  logic [EW-1:0] rd_l, rd_s, rd;

  tbms_heap_mem #(.Depth(HEAP_SIZE), .AddrW(AW)) u_large (
    .clk_i(clk_i), .req_i(req_l), .rdata_o(rd_l));
  tbms_heap_mem #(.Depth(HEAP_SIZE), .AddrW(AW)) u_small (
    .clk_i(clk_i), .req_i(req_s), .rdata_o(rd_s));

  assign rd = heap_q ? rd_s : rd_l;
  assign cfg_ready = 1'b1;
  assign in_stall = (state_q != StIdle) || outv_q;
  assign out_valid = outv_q;
  assign out_data_o = res_q;

  logic [3:0] used;
  logic [tbms_pkg::TupleW-1:0] tup;
  logic [tbms_pkg::PivW-1:0] pv [8];
  logic [SW-1:0] ps, ls, rs, cs;
  logic right_better, stop;
  logic [CW:0] lc;

  always_comb begin
    used = (piv_q > 4'(MAX_PIVOTS)) ? 4'(MAX_PIVOTS) : piv_q;
    pv[0] = cur_q.pivot_0; pv[1] = cur_q.pivot_1; pv[2] = cur_q.pivot_2;
    pv[3] = cur_q.pivot_3; pv[4] = cur_q.pivot_4; pv[5] = cur_q.pivot_5;
    pv[6] = cur_q.pivot_6; pv[7] = cur_q.pivot_7;
    for (int i = 0; i < 8; i++) begin
      tup[(7-i)*10 +: 10] = (4'(i) < used) ?
          (pv[i] & 10'((11'd1 << INDEX_BITS) - 11'd1)) : 10'd0;
    end
  end

  always_comb begin
    ps = pe_q[EW-1 -: SW];
    ls = le_q[EW-1 -: SW];
    rs = rd[EW-1 -: SW];
    right_better = 1'b0;
    if ({1'b0, ch_q} + (CW+1)'(1) < (CW+1)'(HEAP_SIZE)) begin
      right_better = heap_q ? (ls < rs) : (ls > rs);
    end
    cs = right_better ? rs : ls;
    stop = heap_q ? (ps > cs) : (ps < cs);
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; cur_d = cur_q; res_d = res_q;
    new_d = new_q; pe_d = pe_q; le_d = le_q; par_d = par_q; ch_d = ch_q;
    bld_d = bld_q; heap_d = heap_q; build_d = build_q; pend_d = pend_q;
    req = '0;
    req_l = '0;
    req_s = '0;
    lc = '0;
    case (state_q)
      StIdle: begin
        if (in_valid && !outv_q) begin
          cur_d = in_data_i;
          res_d = '0;
          if (in_data_i.op == tbms_pkg::OpOffer) begin
            state_d = StRoot;
          end else if (in_data_i.op == tbms_pkg::OpReadLarge ||
                       in_data_i.op == tbms_pkg::OpReadSmall) begin
            heap_d = (in_data_i.op == tbms_pkg::OpReadSmall);
            state_d = StReadW;
          end else begin
            state_d = StOut;
          end
        end
      end
      StReadW: begin
        req.raddr = 16'(cur_q.slot);
        state_d = StReadD;
      end
      StReadD: begin
        if (CW'(cur_q.slot) < fill_q && 32'(cur_q.slot) < HEAP_SIZE) begin
          res_d.out_score = rd[EW-1 -: SW];
          {res_d.out_pivot_0, res_d.out_pivot_1, res_d.out_pivot_2,
           res_d.out_pivot_3, res_d.out_pivot_4, res_d.out_pivot_5,
           res_d.out_pivot_6, res_d.out_pivot_7} = rd[tbms_pkg::TupleW-1:0];
          res_d.slot_valid = 1'b1;
        end
        state_d = StOut;
      end
      StRoot: begin
        new_d = {cur_q.score, tup};
        if (fill_q < CW'(HEAP_SIZE)) begin
          req_l.we = 1'b1; req_l.waddr = 16'(fill_q); req_l.wdata = {cur_q.score, tup};
          req_s = req_l;
          res_d.took_largest = 1'b1;
          res_d.took_smallest = 1'b1;
          fill_d = fill_q + 1'b1;
          if (fill_q == CW'(HEAP_SIZE - 1)) begin
            build_d = 1'b1; pend_d = 1'b1; heap_d = 1'b0;
            bld_d = CW'(HEAP_SIZE / 2 - 1);
            par_d = CW'(HEAP_SIZE / 2 - 1);
            state_d = StRdP;
          end else begin
            state_d = StOut;
          end
        end else begin
          build_d = 1'b0; pend_d = 1'b1; heap_d = 1'b0;
          req_l.raddr = '0;
          state_d = StRootD;
        end
      end
      StRootD: begin
        // Root of the current heap is on rd; decide replacement.
        if (heap_q ? (cur_q.score < rd[EW-1 -: SW]) : (cur_q.score > rd[EW-1 -: SW])) begin
          req.we = 1'b1; req.waddr = '0; req.wdata = new_q;
          if (heap_q) res_d.took_smallest = 1'b1; else res_d.took_largest = 1'b1;
          pe_d = new_q; par_d = '0; ch_d = CW'(1);
          state_d = StRdL;
          req.raddr = 16'(1);
        end else begin
          // The root stays; it is written back unchanged.
          pe_d = rd; par_d = '0;
          state_d = StNext;
        end
      end
      StRdP: begin
        req.raddr = 16'(par_q);
        lc = {par_q, 1'b1};
        ch_d = CW'(lc);
        state_d = StRdL;
      end
      StRdL: begin
        req.raddr = 16'(ch_q);
        state_d = StRdR;
        if ({1'b0, ch_q} >= (CW+1)'(HEAP_SIZE)) state_d = StNext;
      end
      StRdR: begin
        le_d = rd;
        req.raddr = 16'(ch_q + 1'b1);
        state_d = StCmp;
      end
      StCmp: begin
        if (stop) begin
          state_d = StNext;
        end else begin
          req.we = 1'b1;
          req.waddr = 16'(par_q);
          req.wdata = right_better ? rd : le_q;
          par_d = right_better ? ch_q + 1'b1 : ch_q;
          lc = {par_d, 1'b1};
          ch_d = CW'(lc);
          if (lc >= (CW+1)'(HEAP_SIZE)) begin
            state_d = StNext;
          end else begin
            state_d = StRdL;
          end
        end
      end
      StNext: begin
        // Place the sifted entry at its final slot.
        req.we = 1'b1; req.waddr = 16'(par_q); req.wdata = pe_q;
        if (build_q && bld_q != '0) begin
          bld_d = bld_q - 1'b1; par_d = bld_q - 1'b1;
          state_d = StRdP;
        end else if (pend_q) begin
          pend_d = 1'b0; heap_d = 1'b1;
          if (build_q) begin
            bld_d = CW'(HEAP_SIZE / 2 - 1); par_d = CW'(HEAP_SIZE / 2 - 1);
            state_d = StRdP;
          end else begin
            req_s.raddr = '0;
            state_d = StRootD;
          end
        end else begin
          state_d = StOut;
        end
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q != StIdle && state_q != StRoot && state_q != StReadW &&
        state_q != StReadD && state_q != StOut) begin
      if (heap_q) begin
        req_s = req;
      end else begin
        req_l.we = req.we; req_l.waddr = req.waddr; req_l.wdata = req.wdata;
        req_l.raddr = req.raddr;
      end
    end else if (state_q == StReadW) begin
      req_l = req; req_s = req;
    end
  end

  // Parent entry capture after the StRdP read.
  logic got_par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      piv_q <= 4'd8;
      fill_q <= '0;
      outv_q <= 1'b0;
      heap_q <= 1'b0;
      build_q <= 1'b0;
      pend_q <= 1'b0;
      got_par_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      heap_q <= (state_q == StIdle && state_d == StRoot) ? 1'b0 : heap_d;
      build_q <= build_d;
      pend_q <= pend_d;
      got_par_q <= (state_q == StRdP);
      if (cfg_valid) piv_q <= cfg_data_i;
      if (state_q == StOut) outv_q <= 1'b1;
      else if (!out_stall) outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; res_q <= res_d; new_q <= new_d;
    pe_q <= got_par_q ? rd : pe_d;
    le_q <= le_d; par_q <= par_d; ch_q <= ch_d; bld_q <= bld_d;
  end

endmodule

@@ rtl/tbms_heap_mem.sv @@
// Synchronous heap store with one write port and one registered read port.
module tbms_heap_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic clk_i,
  input  tbms_pkg::mem_req_t req_i,
  output logic [tbms_pkg::EntryW-1:0] rdata_o
);

  logic [tbms_pkg::EntryW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AddrW-1:0]] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr[AddrW-1:0]];
  end

endmodule

@@ test/testbench.sv @@
// Testbench for the top/bottom-M score tracker: directed table, then random offers and reads.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 1024;
  localparam int unsigned WatchdogLimit = 200000;

  typedef struct {
    tbms_pkg::in_word_t word;
    bit has_fixed;
    tbms_pkg::out_word_t fixed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tbms_pkg::in_word_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tbms_pkg::out_word_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data_i = '0;

  top_bottom_m_score_tracker dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  logic [3:0] pivot_count;
  int unsigned fill_level;
  logic [tbms_pkg::ScoreW-1:0] large_score [Depth];
  logic [tbms_pkg::TupleW-1:0] large_tuple [Depth];
  logic [tbms_pkg::ScoreW-1:0] small_score [Depth];
  logic [tbms_pkg::TupleW-1:0] small_tuple [Depth];

  tbms_pkg::out_word_t expected_words [$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_off = 1'b0;
  bit finished = 1'b0;
  stim_row_t table_rows [$];

  function automatic bit heap_wins(bit min_heap, logic [tbms_pkg::ScoreW-1:0] a,
                                   logic [tbms_pkg::ScoreW-1:0] b);
    return min_heap ? (a < b) : (a > b);
  endfunction

  task automatic sift_heap(bit min_heap, int unsigned start);
    int unsigned parent;
    int unsigned child;
    logic [tbms_pkg::ScoreW-1:0] s;
    logic [tbms_pkg::TupleW-1:0] t;
    parent = start;
    child = 2 * parent + 1;
    while (child < Depth) begin
      if (min_heap) begin
        if (child + 1 < Depth && large_score[child] > large_score[child+1]) child++;
        if (large_score[parent] < large_score[child]) return;
        s = large_score[parent]; large_score[parent] = large_score[child]; large_score[child] = s;
        t = large_tuple[parent]; large_tuple[parent] = large_tuple[child]; large_tuple[child] = t;
      end else begin
        if (child + 1 < Depth && small_score[child] < small_score[child+1]) child++;
        if (small_score[parent] > small_score[child]) return;
        s = small_score[parent]; small_score[parent] = small_score[child]; small_score[child] = s;
        t = small_tuple[parent]; small_tuple[parent] = small_tuple[child]; small_tuple[child] = t;
      end
      parent = child;
      child = 2 * parent + 1;
    end
  endtask

  task automatic track_word(input tbms_pkg::in_word_t w, output tbms_pkg::out_word_t r);
    logic [tbms_pkg::PivW-1:0] piv [tbms_pkg::NumPiv];
    logic [tbms_pkg::TupleW-1:0] tuple;
    logic [tbms_pkg::TupleW-1:0] got;
    int unsigned used;
    r = '0;
    used = (pivot_count > tbms_pkg::NumPiv) ? tbms_pkg::NumPiv : pivot_count;
    piv[0] = w.pivot_0; piv[1] = w.pivot_1; piv[2] = w.pivot_2; piv[3] = w.pivot_3;
    piv[4] = w.pivot_4; piv[5] = w.pivot_5; piv[6] = w.pivot_6; piv[7] = w.pivot_7;
    tuple = '0;
    for (int i = 0; i < tbms_pkg::NumPiv; i++)
      if (i < used) tuple[tbms_pkg::TupleW-1-i*tbms_pkg::PivW -: tbms_pkg::PivW] = piv[i];
    if (w.op == tbms_pkg::OpOffer) begin
      if (fill_level < Depth) begin
        large_score[fill_level] = w.score; large_tuple[fill_level] = tuple;
        small_score[fill_level] = w.score; small_tuple[fill_level] = tuple;
        r.took_largest = 1'b1;
        r.took_smallest = 1'b1;
        if (fill_level == Depth - 1)
          for (int k = Depth / 2 - 1; k >= 0; k--) begin
            sift_heap(1'b1, k);
            sift_heap(1'b0, k);
          end
        fill_level++;
      end else begin
        if (heap_wins(1'b0, w.score, large_score[0])) begin
          large_score[0] = w.score; large_tuple[0] = tuple;
          sift_heap(1'b1, 0);
          r.took_largest = 1'b1;
        end
        if (heap_wins(1'b1, w.score, small_score[0])) begin
          small_score[0] = w.score; small_tuple[0] = tuple;
          sift_heap(1'b0, 0);
          r.took_smallest = 1'b1;
        end
      end
    end else if ((w.op == tbms_pkg::OpReadLarge || w.op == tbms_pkg::OpReadSmall) &&
                 w.slot < fill_level) begin
      r.out_score = (w.op == tbms_pkg::OpReadLarge) ? large_score[w.slot] : small_score[w.slot];
      got = (w.op == tbms_pkg::OpReadLarge) ? large_tuple[w.slot] : small_tuple[w.slot];
      {r.out_pivot_0, r.out_pivot_1, r.out_pivot_2, r.out_pivot_3,
       r.out_pivot_4, r.out_pivot_5, r.out_pivot_6, r.out_pivot_7} = got;
      r.slot_valid = 1'b1;
    end
  endtask

  function automatic tbms_pkg::in_word_t make_word(logic [1:0] op, logic [9:0] slot,
                                                   logic [tbms_pkg::ScoreW-1:0] score);
    tbms_pkg::in_word_t w;
    w = '0;
    w.op = op;
    w.slot = slot;
    w.score = score;
    {w.pivot_0, w.pivot_1, w.pivot_2, w.pivot_3} = 40'({$urandom, $urandom});
    {w.pivot_4, w.pivot_5, w.pivot_6, w.pivot_7} = 40'({$urandom, $urandom});
    return w;
  endfunction

  function automatic logic [tbms_pkg::ScoreW-1:0] rand_score();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return tbms_pkg::ScoreW'($urandom_range(0, 15));
      default: return tbms_pkg::ScoreW'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_word(tbms_pkg::in_word_t w, bit has_fixed, tbms_pkg::out_word_t fixed);
    tbms_pkg::out_word_t r;
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    track_word(w, r);
    if (has_fixed && r != fixed) begin
      $error("table row mismatch with predictor: word %h", w);
      error_count++;
    end
    expected_words.push_back(r);
    in_valid <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_pivot_count(logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pivot_count = value;
  endtask

  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
  end

  always @(posedge clk_i) begin
    tbms_pkg::out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word %h arrived with none expected", out_data_o);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (want.out_score !== out_data_o.out_score) begin
          $error("out_score: expected %h, got %h", want.out_score, out_data_o.out_score);
          error_count++;
        end
        if (want.out_pivot_0 !== out_data_o.out_pivot_0) begin
          $error("out_pivot_0: expected %h, got %h", want.out_pivot_0, out_data_o.out_pivot_0);
          error_count++;
        end
        if (want.out_pivot_1 !== out_data_o.out_pivot_1) begin
          $error("out_pivot_1: expected %h, got %h", want.out_pivot_1, out_data_o.out_pivot_1);
          error_count++;
        end
        if (want.out_pivot_2 !== out_data_o.out_pivot_2) begin
          $error("out_pivot_2: expected %h, got %h", want.out_pivot_2, out_data_o.out_pivot_2);
          error_count++;
        end
        if (want.out_pivot_3 !== out_data_o.out_pivot_3) begin
          $error("out_pivot_3: expected %h, got %h", want.out_pivot_3, out_data_o.out_pivot_3);
          error_count++;
        end
        if (want.out_pivot_4 !== out_data_o.out_pivot_4) begin
          $error("out_pivot_4: expected %h, got %h", want.out_pivot_4, out_data_o.out_pivot_4);
          error_count++;
        end
        if (want.out_pivot_5 !== out_data_o.out_pivot_5) begin
          $error("out_pivot_5: expected %h, got %h", want.out_pivot_5, out_data_o.out_pivot_5);
          error_count++;
        end
        if (want.out_pivot_6 !== out_data_o.out_pivot_6) begin
          $error("out_pivot_6: expected %h, got %h", want.out_pivot_6, out_data_o.out_pivot_6);
          error_count++;
        end
        if (want.out_pivot_7 !== out_data_o.out_pivot_7) begin
          $error("out_pivot_7: expected %h, got %h", want.out_pivot_7, out_data_o.out_pivot_7);
          error_count++;
        end
        if (want.slot_valid !== out_data_o.slot_valid) begin
          $error("slot_valid: expected %b, got %b", want.slot_valid, out_data_o.slot_valid);
          error_count++;
        end
        if (want.took_largest !== out_data_o.took_largest) begin
          $error("took_largest: expected %b, got %b", want.took_largest, out_data_o.took_largest);
          error_count++;
        end
        if (want.took_smallest !== out_data_o.took_smallest) begin
          $error("took_smallest: expected %b, got %b", want.took_smallest,
                 out_data_o.took_smallest);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || finished || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic hold_receiver();
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  initial begin
    stim_row_t row;
    tbms_pkg::out_word_t zero_word;
    logic [3:0] settings [6];
    settings = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8};
    zero_word = '0;
    pivot_count = 4'd8;
    fill_level = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads of empty stores and the unused op give all zeros; first offers go to both sets.
    row.has_fixed = 1'b1;
    row.fixed = zero_word;
    row.word = make_word(tbms_pkg::OpReadLarge, 10'd0, '0); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpReadSmall, 10'd1023, '1); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpNone, 10'd5, '1); table_rows.push_back(row);
    row.fixed.took_largest = 1'b1;
    row.fixed.took_smallest = 1'b1;
    row.word = make_word(tbms_pkg::OpOffer, 10'd0, '0); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpOffer, 10'd1023, '1); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpOffer, 10'd3, 48'd1); table_rows.push_back(row);
    row.has_fixed = 1'b0;
    row.word = make_word(tbms_pkg::OpReadLarge, 10'd0, '0); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpReadSmall, 10'd1, '0); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpReadLarge, 10'd2, '0); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpReadSmall, 10'd3, '0); table_rows.push_back(row);
    row.word = make_word(tbms_pkg::OpNone, 10'd0, '0); table_rows.push_back(row);
    foreach (table_rows[i]) send_word(table_rows[i].word, table_rows[i].has_fixed,
                                      table_rows[i].fixed);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      write_pivot_count(settings[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 77; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 77; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      fork
        if (phase == 0) hold_receiver();
        for (int n = 0; n < 175; n++) begin
          tbms_pkg::in_word_t w;
          int unsigned pick;
          pick = $urandom_range(0, 99);
          // Only offers until the heaps are built, so that replacement is reached.
          if (fill_level < Depth || pick < 60)
            w = make_word(tbms_pkg::OpOffer, 10'($urandom), rand_score());
          else if (pick < 78)
            w = make_word(tbms_pkg::OpReadLarge, (pick & 1) ? 10'($urandom) :
                          10'($urandom_range(0, fill_level == 0 ? 0 : fill_level - 1)), '0);
          else if (pick < 96)
            w = make_word(tbms_pkg::OpReadSmall, 10'($urandom), rand_score());
          else
            w = make_word(tbms_pkg::OpNone, 10'($urandom), rand_score());
          send_word(w, 1'b0, zero_word);
        end
      join
      wait_drained();
    end

    finished = 1'b1;
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
